// ----- rtl/vpp_pkg.sv -----
package vpp_pkg;

  localparam int FRAC_BITS = 16;
  // width of the projected values before the divide
  localparam int VW = 64 - FRAC_BITS;
  localparam int QB = 32;
  localparam int NW = 64;
  localparam int DW = VW;
  localparam int TW = 47;
  localparam int IDXW = 8;
  localparam int SIZEW = 13;
  localparam int LANES = 3;
  localparam int LANE_X = 0;
  localparam int LANE_Y = 1;
  localparam int LANE_Z = 2;

  localparam int FRONT_STAGES = 3;
  localparam int BACK_STAGES = 2;
  localparam int PIPE_CAP = FRONT_STAGES + QB + BACK_STAGES + 2;

  localparam logic [IDXW-1:0] REG_X_SCALE  = IDXW'(0);
  localparam logic [IDXW-1:0] REG_Y_SCALE  = IDXW'(1);
  localparam logic [IDXW-1:0] REG_Z_SCALE  = IDXW'(2);
  localparam logic [IDXW-1:0] REG_Z_OFFSET = IDXW'(3);
  localparam logic [IDXW-1:0] REG_W_FROM_Z = IDXW'(4);
  localparam logic [IDXW-1:0] REG_W_OFFSET = IDXW'(5);
  localparam logic [IDXW-1:0] REG_WIDTH    = IDXW'(6);
  localparam logic [IDXW-1:0] REG_HEIGHT   = IDXW'(7);

  typedef struct packed {
    logic signed [31:0] x_scale;
    logic signed [31:0] y_scale;
    logic signed [31:0] z_scale;
    logic signed [31:0] z_offset;
    logic signed [31:0] w_from_z;
    logic signed [31:0] w_offset;
    logic [SIZEW-1:0]   width;
    logic [SIZEW-1:0]   height;
  } cfg_t;

  typedef struct packed {
    logic [DW-1:0] rem;
    logic [QB-1:0] lo;
    logic [QB-1:0] q;
  } div_lane_t;

  typedef struct packed {
    div_lane_t [LANES-1:0]         lane;
    logic [DW-1:0]                 divisor;
    logic [LANES-1:0]              ovf;
    logic [LANES-1:0]              neg;
    logic [LANES-1:0][VW-1:0]      v;
    logic                          wzero;
    logic [23:0]                   color;
  } div_stage_t;

  typedef struct packed {
    logic [31:0] sx;
    logic [31:0] sy;
    logic [31:0] sz;
    logic [23:0] color;
    logic        wzero;
  } result_t;

  function automatic logic [31:0] clamp_v(input logic signed [VW-1:0] v);
    if (v > $signed({{(VW-31){1'b0}}, {31{1'b1}}})) return 32'h7fffffff;
    else if (v < $signed({{(VW-31){1'b1}}, {31{1'b0}}})) return 32'h80000000;
    else return v[31:0];
  endfunction

  function automatic logic [31:0] clamp_t(input logic signed [TW-1:0] v);
    if (v > $signed({{(TW-31){1'b0}}, {31{1'b1}}})) return 32'h7fffffff;
    else if (v < $signed({{(TW-31){1'b1}}, {31{1'b0}}})) return 32'h80000000;
    else return v[31:0];
  endfunction

endpackage

// ----- rtl/vpp_if.sv -----
interface vpp_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [31:0] pos_z;
  logic [23:0] color_rgb;
  modport source (output valid, pos_x, pos_y, pos_z, color_rgb, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, color_rgb, output ready);
endinterface

interface vpp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] screen_x;
  logic [31:0] screen_y;
  logic [31:0] depth_z;
  logic [23:0] color_out;
  logic        w_was_zero;
  modport source (output valid, screen_x, screen_y, depth_z, color_out, w_was_zero,
                  input ready);
  modport sink (input valid, screen_x, screen_y, depth_z, color_out, w_was_zero,
                output ready);
endinterface

interface vpp_cfg_if;
  import vpp_pkg::*;
  logic            valid;
  logic            ready;
  logic [IDXW-1:0] index;
  logic [31:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/vpp_front.sv -----
module vpp_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic [23:0]        color_i,
  input  vpp_pkg::cfg_t      cfg_i,
  output logic               valid_o,
  output vpp_pkg::div_stage_t stage_o
);
  import vpp_pkg::*;

  logic [FRONT_STAGES-1:0] v_q;
  logic signed [63:0] px_q, py_q, pz_q, pw_q;
  logic [23:0] color1_q, color2_q;
  logic signed [VW-1:0] vx_q, vy_q, vz_q, w_q;
  div_stage_t stage_q;

  logic signed [63:0] oz, ow, sx, sy, sz, sw;
  logic [LANES-1:0][VW-1:0] vv;
  logic [VW-1:0] dmag;
  div_stage_t stage_d;

  always_comb begin
    oz = 64'(cfg_i.z_offset) <<< FRAC_BITS;
    ow = 64'(cfg_i.w_offset) <<< FRAC_BITS;
    sx = px_q >>> FRAC_BITS;
    sy = py_q >>> FRAC_BITS;
    sz = (pz_q + oz) >>> FRAC_BITS;
    sw = (pw_q + ow) >>> FRAC_BITS;
  end

  always_comb begin
    logic [VW-1:0] mag;
    logic [NW-1:0] num;
    vv[LANE_X] = vx_q;
    vv[LANE_Y] = vy_q;
    vv[LANE_Z] = vz_q;
    dmag = w_q[VW-1] ? VW'(-w_q) : w_q;
    stage_d = '0;
    stage_d.divisor = dmag;
    stage_d.v = vv;
    stage_d.wzero = (w_q == '0);
    stage_d.color = color2_q;
    for (int i = 0; i < LANES; i++) begin
      mag = vv[i][VW-1] ? VW'(-$signed(vv[i])) : vv[i];
      num = {mag, {FRAC_BITS{1'b0}}};
      stage_d.ovf[i] = DW'(num[NW-1:QB]) >= dmag;
      stage_d.neg[i] = vv[i][VW-1] ^ w_q[VW-1];
      stage_d.lane[i].rem = DW'(num[NW-1:QB]);
      stage_d.lane[i].lo = num[QB-1:0];
      stage_d.lane[i].q = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[FRONT_STAGES-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q <= pos_x_i * cfg_i.x_scale;
      py_q <= pos_y_i * cfg_i.y_scale;
      pz_q <= pos_z_i * cfg_i.z_scale;
      pw_q <= pos_z_i * cfg_i.w_from_z;
      color1_q <= color_i;
      vx_q <= sx[VW-1:0];
      vy_q <= sy[VW-1:0];
      vz_q <= sz[VW-1:0];
      w_q <= sw[VW-1:0];
      color2_q <= color1_q;
      stage_q <= stage_d;
    end
  end

  assign valid_o = v_q[FRONT_STAGES-1];
  assign stage_o = stage_q;

endmodule

// ----- rtl/vpp_div_cell.sv -----
module vpp_div_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  vpp_pkg::div_stage_t stage_i,
  output logic                valid_o,
  output vpp_pkg::div_stage_t stage_o
);
  import vpp_pkg::*;

  logic       valid_q;
  div_stage_t stage_q, stage_d;

  // one restoring step per lane: one quotient bit
  always_comb begin
    logic [DW:0] trial;
    logic        ge;
    stage_d = stage_i;
    for (int i = 0; i < LANES; i++) begin
      trial = {stage_i.lane[i].rem, stage_i.lane[i].lo[QB-1]};
      ge = trial >= {1'b0, stage_i.divisor};
      stage_d.lane[i].rem = ge ? DW'(trial - {1'b0, stage_i.divisor}) : trial[DW-1:0];
      stage_d.lane[i].lo = {stage_i.lane[i].lo[QB-2:0], 1'b0};
      stage_d.lane[i].q = {stage_i.lane[i].q[QB-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

// ----- rtl/vpp_back.sv -----
module vpp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  vpp_pkg::div_stage_t stage_i,
  input  vpp_pkg::cfg_t       cfg_i,
  output logic                valid_o,
  output vpp_pkg::result_t    result_o
);
  import vpp_pkg::*;

  logic [BACK_STAGES-1:0] v_q;
  logic [LANES-1:0][31:0] c_q;
  logic [23:0] color1_q, color2_q;
  logic wz1_q, wz2_q;
  logic signed [TW-1:0] tx_q, ty_q;
  logic [31:0] cz_q;

  logic [LANES-1:0][31:0] c_d;
  logic signed [32:0] ax, ay;

  // sign, saturation and bypass when w is zero
  always_comb begin
    logic [QB-1:0] mag;
    for (int i = 0; i < LANES; i++) begin
      mag = stage_i.lane[i].q;
      if (stage_i.wzero) begin
        c_d[i] = clamp_v(stage_i.v[i]);
      end else if (!stage_i.neg[i]) begin
        c_d[i] = (stage_i.ovf[i] || mag[QB-1]) ? 32'h7fffffff : mag;
      end else begin
        c_d[i] = (stage_i.ovf[i] || mag > 32'h80000000) ? 32'h80000000 : 32'(-mag);
      end
    end
  end

  always_comb begin
    ax = $signed({c_q[LANE_X][31], c_q[LANE_X]}) + 33'(2 ** FRAC_BITS);
    ay = $signed({c_q[LANE_Y][31], c_q[LANE_Y]}) + 33'(2 ** FRAC_BITS);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[BACK_STAGES-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q <= c_d;
      color1_q <= stage_i.color;
      wz1_q <= stage_i.wzero;
      tx_q <= ax * $signed({1'b0, cfg_i.width});
      ty_q <= ay * $signed({1'b0, cfg_i.height});
      cz_q <= c_q[LANE_Z];
      color2_q <= color1_q;
      wz2_q <= wz1_q;
    end
  end

  assign valid_o = v_q[BACK_STAGES-1];
  assign result_o.sx = clamp_t(tx_q >>> 1);
  assign result_o.sy = clamp_t(ty_q >>> 1);
  assign result_o.sz = cz_q;
  assign result_o.color = color2_q;
  assign result_o.wzero = wz2_q;

endmodule

// ----- rtl/vertex_perspective_projection_top.sv -----
// Vertex perspective projection: each vertex is scaled by the sparse projection
// matrix, divided by w (32-bit signed saturated quotients, w_was_zero set and the
// divide skipped when w is zero), mapped to the viewport, and the colour passed
// through. One vertex is accepted per cycle while the skid register is empty; a result
// passes through 3 front stages, a chain of 32 restoring divider cells that each
// produce one quotient bit for x, y and z, 2 back stages and the output
// register. A skid register lets the input keep accepting while a result waits.
// Configuration writes must only be issued when idle; the port's ready is tied high.
module vertex_perspective_projection_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  vpp_in_if.sink    in_i,
  vpp_out_if.source out_o,
  vpp_cfg_if.sink   cfg_i
);
  import vpp_pkg::*;

  cfg_t cfg_q;
  logic en;
  logic front_v, back_v;
  div_stage_t front_s;
  logic [QB:0] dv;
  div_stage_t chain [QB+1];
  result_t pipe_d, out_d_q, skid_d_q;
  logic out_v_q, skid_v_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_scale  <= 32'sd65536;
      cfg_q.y_scale  <= 32'sd65536;
      cfg_q.z_scale  <= 32'sd65536;
      cfg_q.z_offset <= '0;
      cfg_q.w_from_z <= 32'sd65536;
      cfg_q.w_offset <= '0;
      cfg_q.width    <= SIZEW'(640);
      cfg_q.height   <= SIZEW'(480);
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_X_SCALE:  cfg_q.x_scale  <= cfg_i.data;
        REG_Y_SCALE:  cfg_q.y_scale  <= cfg_i.data;
        REG_Z_SCALE:  cfg_q.z_scale  <= cfg_i.data;
        REG_Z_OFFSET: cfg_q.z_offset <= cfg_i.data;
        REG_W_FROM_Z: cfg_q.w_from_z <= cfg_i.data;
        REG_W_OFFSET: cfg_q.w_offset <= cfg_i.data;
        REG_WIDTH:    cfg_q.width    <= cfg_i.data[SIZEW-1:0];
        REG_HEIGHT:   cfg_q.height   <= cfg_i.data[SIZEW-1:0];
        default: ;
      endcase
    end
  end

  // whole pipeline holds while the skid register is full
  assign en = !skid_v_q;
  assign in_i.ready = en;

  vpp_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid),
    .pos_x_i (in_i.pos_x),
    .pos_y_i (in_i.pos_y),
    .pos_z_i (in_i.pos_z),
    .color_i (in_i.color_rgb),
    .cfg_i   (cfg_q),
    .valid_o (front_v),
    .stage_o (front_s)
  );

  assign dv[0] = front_v;
  assign chain[0] = front_s;

  for (genvar k = 0; k < QB; k++) begin : g_div
    vpp_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv[k]),
      .stage_i (chain[k]),
      .valid_o (dv[k+1]),
      .stage_o (chain[k+1])
    );
  end

  vpp_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (dv[QB]),
    .stage_i  (chain[QB]),
    .cfg_i    (cfg_q),
    .valid_o  (back_v),
    .result_o (pipe_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || out_o.ready) begin
      out_v_q <= skid_v_q | back_v;
      skid_v_q <= 1'b0;
    end else if (back_v && en) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || out_o.ready) begin
      out_d_q <= skid_v_q ? skid_d_q : pipe_d;
    end
    if (out_v_q && !out_o.ready && !skid_v_q) begin
      skid_d_q <= pipe_d;
    end
  end

  assign out_o.valid = out_v_q;
  assign out_o.screen_x = out_d_q.sx;
  assign out_o.screen_y = out_d_q.sy;
  assign out_o.depth_z = out_d_q.sz;
  assign out_o.color_out = out_d_q.color;
  assign out_o.w_was_zero = out_d_q.wzero;

endmodule

// ----- rtl/vpp_checker.sv -----
module vpp_assert (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic cfg_ready_i
);
  import vpp_pkg::*;

  localparam int CW = $clog2(PIPE_CAP + 2);

  logic [CW-1:0] cnt_q;
  logic in_acc, out_acc;

  assign in_acc = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_q + CW'(in_acc) - CW'(out_acc);
    end
  end

  // no result without an outstanding request
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> cnt_q != '0) else $error("result without a request");

  a_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(PIPE_CAP)) else $error("too many requests in flight");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i) else $error("result dropped");

  a_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_i) else $error("config port not ready");

endmodule

bind vertex_perspective_projection_top vpp_assert u_vpp_assert (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .cfg_ready_i (cfg_i.ready)
);

// ----- dv/vpp_checker.sv -----
module vpp_checker (
  input  logic clk_i,
  input  logic rst_ni,
  vpp_in_if    in_if,
  vpp_out_if   out_if,
  vpp_cfg_if   cfg_if,
  output int   fail_count,
  output int   pending_count
);
  import vpp_pkg::*;

  localparam longint ONE = longint'(1) << FRAC_BITS;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;

  cfg_t    matrix_cfg;
  result_t projected_q[$];
  int      mismatches;

  function automatic longint sat32(input longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  function automatic logic [31:0] to_screen(input longint q, input logic [SIZEW-1:0] size);
    longint t;
    t = (q + ONE) * longint'({51'b0, size});
    return 32'(sat32(t >>> 1));
  endfunction

  function automatic result_t project_vertex(input logic [31:0] px, input logic [31:0] py,
                                             input logic [31:0] pz, input logic [23:0] rgb,
                                             input cfg_t c);
    longint  x, y, z, vx, vy, vz, w;
    result_t r;
    x  = longint'($signed(px));
    y  = longint'($signed(py));
    z  = longint'($signed(pz));
    vx = (x * longint'(c.x_scale)) >>> FRAC_BITS;
    vy = (y * longint'(c.y_scale)) >>> FRAC_BITS;
    vz = (z * longint'(c.z_scale) + longint'(c.z_offset) * ONE) >>> FRAC_BITS;
    w  = (z * longint'(c.w_from_z) + longint'(c.w_offset) * ONE) >>> FRAC_BITS;
    r.wzero = (w == 0);
    if (!r.wzero) begin
      vx = (vx * ONE) / w;
      vy = (vy * ONE) / w;
      vz = (vz * ONE) / w;
    end
    vx = sat32(vx);
    vy = sat32(vy);
    vz = sat32(vz);
    r.sx = to_screen(vx, c.width);
    r.sy = to_screen(vy, c.height);
    r.sz = 32'(vz);
    r.color = rgb;
    return r;
  endfunction

  assign pending_count = projected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      matrix_cfg.x_scale  <= 32'sd65536;
      matrix_cfg.y_scale  <= 32'sd65536;
      matrix_cfg.z_scale  <= 32'sd65536;
      matrix_cfg.z_offset <= 32'sd0;
      matrix_cfg.w_from_z <= 32'sd65536;
      matrix_cfg.w_offset <= 32'sd0;
      matrix_cfg.width    <= 13'd640;
      matrix_cfg.height   <= 13'd480;
      fail_count <= 0;
      mismatches = 0;
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          REG_X_SCALE:  matrix_cfg.x_scale  <= cfg_if.data;
          REG_Y_SCALE:  matrix_cfg.y_scale  <= cfg_if.data;
          REG_Z_SCALE:  matrix_cfg.z_scale  <= cfg_if.data;
          REG_Z_OFFSET: matrix_cfg.z_offset <= cfg_if.data;
          REG_W_FROM_Z: matrix_cfg.w_from_z <= cfg_if.data;
          REG_W_OFFSET: matrix_cfg.w_offset <= cfg_if.data;
          REG_WIDTH:    matrix_cfg.width    <= cfg_if.data[SIZEW-1:0];
          REG_HEIGHT:   matrix_cfg.height   <= cfg_if.data[SIZEW-1:0];
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready)
        projected_q.push_back(project_vertex(in_if.pos_x, in_if.pos_y, in_if.pos_z,
                                             in_if.color_rgb, matrix_cfg));
      if (out_if.valid && out_if.ready) begin
        if (projected_q.size() == 0) begin
          fail_count <= fail_count + 1;
          mismatches++;
          if (mismatches <= 10) $display("unexpected result x=%h y=%h", out_if.screen_x,
                                         out_if.screen_y);
        end else begin
          want = projected_q.pop_front();
          if (out_if.screen_x !== want.sx || out_if.screen_y !== want.sy ||
              out_if.depth_z !== want.sz || out_if.color_out !== want.color ||
              out_if.w_was_zero !== want.wzero) begin
            fail_count <= fail_count + 1;
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp x=%h y=%h z=%h c=%h wz=%b got x=%h y=%h z=%h c=%h wz=%b",
                       want.sx, want.sy, want.sz, want.color, want.wzero,
                       out_if.screen_x, out_if.screen_y, out_if.depth_z,
                       out_if.color_out, out_if.w_was_zero);
          end
        end
      end
    end
  end
endmodule

// ----- dv/testbench.sv -----
module testbench;
  import vpp_pkg::*;

  logic clk_i;
  logic rst_ni;
  logic steady;
  int   fail_count;
  int   pending_count;

  vpp_in_if  in_if ();
  vpp_out_if out_if ();
  vpp_cfg_if cfg_if ();

  vertex_perspective_projection_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  vpp_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_if         (in_if),
    .out_if        (out_if),
    .cfg_if        (cfg_if),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // result side back-pressure
  always @(negedge clk_i) begin
    out_if.ready <= steady || ($urandom_range(99) >= 24);
  end

  // mostly small coordinates so the divide stays in range, sometimes full scale
  function automatic logic [31:0] rand_fix();
    if ($urandom_range(9) < 7) return 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);
    return $urandom;
  endfunction

  task automatic write_reg(input logic [IDXW-1:0] idx, input logic [31:0] value);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic send_vertex(input logic [31:0] px, input logic [31:0] py,
                             input logic [31:0] pz, input logic [23:0] rgb);
    @(negedge clk_i);
    while (!steady && $urandom_range(99) < 24) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.pos_x     <= px;
    in_if.pos_y     <= py;
    in_if.pos_z     <= pz;
    in_if.color_rgb <= rgb;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (45) @(negedge clk_i);
  endtask

  task automatic load_matrix(input logic [31:0] sx, input logic [31:0] sy,
                             input logic [31:0] sz, input logic [31:0] oz,
                             input logic [31:0] wz, input logic [31:0] ow,
                             input logic [31:0] wd, input logic [31:0] ht);
    write_reg(REG_X_SCALE, sx);
    write_reg(REG_Y_SCALE, sy);
    write_reg(REG_Z_SCALE, sz);
    write_reg(REG_Z_OFFSET, oz);
    write_reg(REG_W_FROM_Z, wz);
    write_reg(REG_W_OFFSET, ow);
    write_reg(REG_WIDTH, wd);
    write_reg(REG_HEIGHT, ht);
  endtask

  initial begin
    rst_ni = 1'b0;
    steady = 1'b0;
    in_if.valid = 1'b0;
    in_if.pos_x = '0;
    in_if.pos_y = '0;
    in_if.pos_z = '0;
    in_if.color_rgb = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset matrix: w equals z, so zero z skips the divide
    send_vertex(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 24'h000000);
    send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000, 24'hffffff);
    send_vertex(32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001, 24'h123456);
    send_vertex(32'h0003_0000, 32'hfffd_0000, 32'h0000_0000, 24'hff00ff);
    send_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h0000_0000, 24'h00ff00);
    send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 24'h0f0f0f);
    send_vertex(32'h7fff_ffff, 32'h0000_0000, 32'h7fff_ffff, 24'hf0f0f0);
    send_vertex(32'h0002_8000, 32'hffff_8000, 32'hffff_0000, 24'haaaaaa);
    send_vertex(32'hffff_ffff, 32'h0000_0001, 32'hffff_ffff, 24'h555555);
    send_vertex(32'h0000_8000, 32'h0000_8000, 32'h0000_ffff, 24'h800001);
    send_vertex(32'h0010_0000, 32'hfff0_0000, 32'h0000_8000, 24'h7ffffe);
    drain();

    for (int k = 0; k < 10; k++) begin
      case (k)
        0: load_matrix(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                       32'h7fffffff, 32'h7fffffff, 32'd4096, 32'd4096);
        1: load_matrix(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                       32'h80000000, 32'h80000000, 32'd1, 32'd1);
        // w forced to zero, size zero and the full 13-bit size
        2: load_matrix(32'h00020000, 32'hfffe0000, 32'h00010000, 32'h00008000,
                       32'h0, 32'h0, 32'h0, 32'h1fff);
        3: begin
          load_matrix(32'h00010000, 32'h00010000, 32'h00010000, 32'h0,
                      32'hffff0000, 32'h00020000, 32'hffffffff, 32'd1080);
          // writes past the register list must be ignored
          write_reg(IDXW'(8), 32'h0);
          write_reg(IDXW'(255), 32'h0);
        end
        default: load_matrix(rand_fix(), rand_fix(), rand_fix(), rand_fix(),
                             ($urandom_range(7) == 0) ? 32'h0 : rand_fix(), rand_fix(),
                             $urandom_range(1, 4096), $urandom_range(1, 4096));
      endcase
      steady = (k == 5);
      for (int n = 0; n < 50; n++)
        send_vertex(rand_fix(), rand_fix(),
                    ($urandom_range(9) == 0) ? 32'h0 : rand_fix(), 24'($urandom));
      drain();
    end

    if (fail_count == 0 && pending_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #400000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
